FILE: design/vibc_pkg.sv
// Package for the voxel interior block cull unit.
// Holds section geometry, voxel and neighbor types and the config index codes.
// No dependencies.
`default_nettype none

package vibc_pkg;

  localparam int EDGE_BITS  = 4;
  localparam int EDGE       = 1 << EDGE_BITS;
  localparam int PLANE      = EDGE * EDGE;
  localparam int PLANE_AW   = 2 * EDGE_BITS;
  localparam int IDX_BITS   = 3 * EDGE_BITS;
  localparam int ID_W       = 12;
  localparam int STATE_W    = 4;
  localparam int SEC_XZ_W   = 22;
  localparam int SEC_Y_W    = 4;
  localparam int WORLD_XZ_W = SEC_XZ_W + EDGE_BITS;
  localparam int WORLD_Y_W  = SEC_Y_W + EDGE_BITS;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 80;
  localparam int OUT_FILL_W = OUT_DATA_W - (ID_W + STATE_W + 2 * WORLD_XZ_W + WORLD_Y_W);

  localparam logic [EDGE_BITS-1:0] EDGE_MAX = EDGE_BITS'(EDGE - 1);

  typedef logic [EDGE_BITS-1:0] coord_t;

  typedef struct packed {
    logic [STATE_W-1:0] state;
    logic [ID_W-1:0]    id;
  } voxel_t;

  typedef struct packed {
    voxel_t below;
    logic   xp;
    logic   xm;
    logic   zp;
    logic   zm;
    logic   yb;
  } nbr_t;

  typedef enum logic [1:0] {
    CFG_SECTION_X = 2'd0,
    CFG_SECTION_Y = 2'd1,
    CFG_SECTION_Z = 2'd2
  } cfg_idx_t;

  function automatic logic is_solid(voxel_t v);
    return v.id != '0;
  endfunction

endpackage

`default_nettype wire

FILE: design/vibc_window.sv
// Two-plane neighbor window: a one-plane line buffer for the voxel below the
// incoming one, and a shift line of solid bits for its neighbors.
// Depends on vibc_pkg.
`default_nettype none

module vibc_window
  import vibc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                shift_en,
  input  wire logic [PLANE_AW-1:0] wr_addr,
  input  wire logic [PLANE_AW-1:0] rd_addr,
  input  wire voxel_t              vox_in,
  output nbr_t                     nbr
);

  voxel_t               line_mem [PLANE];
  voxel_t               below_r;
  logic [2*PLANE-1:0]   sol_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      line_mem[wr_addr] <= vox_in;
    end
    below_r <= line_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      sol_r <= {sol_r[2*PLANE-2:0], is_solid(vox_in)};
    end
  end

  assign nbr.below = below_r;
  assign nbr.xp    = sol_r[PLANE-2];
  assign nbr.xm    = sol_r[PLANE];
  assign nbr.zp    = sol_r[PLANE-EDGE-1];
  assign nbr.zm    = sol_r[PLANE+EDGE-1];
  assign nbr.yb    = sol_r[2*PLANE-1];

endmodule

`default_nettype wire

FILE: design/voxel_interior_block_cull_unit.sv
// Voxel interior block cull unit: top level.
// Depends on vibc_pkg and vibc_window.
//
// Usage:
//  - in_* carries the 16x16x16 voxels of one section in scan order
//    (x fastest, then z, then y), one transfer per voxel.
//  - out_* carries each visible voxel with its world position; out_tlast
//    marks the final result caused by an input transfer.
//  - cfg_* sets the section coordinates; write them while the unit is idle.
//  - A voxel is decided when the voxel above it arrives; in the top plane an
//    input transfer yields the voxel below, then itself.
//  - A result passes through the decision stage and then the output register
//    after the input transfer that causes it.
//  - Throughput: one voxel per cycle while the receiver keeps up; top-plane
//    voxels with two results stall the input, as the single output register takes one at a time.
//  - Reset clears the scan position, the section registers and all valid
//    flags; the plane buffer needs no clearing, scan order writes each entry
//    before it is read.
//  - When the receiver stalls, results hold in the output register and the
//    decision stage, and in_tready drops once both are full.
`default_nettype none

module voxel_interior_block_cull_unit
  import vibc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // block_id [11:0], block_state [15:12]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // out_id [11:0], out_state [15:12], world_x [41:16], world_y [49:42],
  // world_z [75:50], zero fill [79:76]
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic                       out_tlast,
  input  wire logic                  cfg_wr_en,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [SEC_XZ_W-1:0]   cfg_wdata
);

  logic [SEC_XZ_W-1:0] sec_x_r;
  logic [SEC_Y_W-1:0]  sec_y_r;
  logic [SEC_XZ_W-1:0] sec_z_r;

  logic [IDX_BITS-1:0] idx_r;

  logic   s_b_v_r, s_c_v_r;
  voxel_t s_b_r, s_c_r;
  coord_t s_x_r, s_y_r, s_z_r;

  logic                  out_v_r;
  logic                  out_last_r;
  voxel_t                out_vox_r;
  logic [WORLD_XZ_W-1:0] out_wx_r;
  logic [WORLD_Y_W-1:0]  out_wy_r;
  logic [WORLD_XZ_W-1:0] out_wz_r;

  voxel_t cur;
  nbr_t   nbr;
  coord_t cx, cy, cz, by;
  logic   in_fire, out_ld, s_any, s_two;
  logic   b_emit, c_emit, on_edge, enclosed;
  voxel_t sel_vox;
  coord_t sel_y;
  logic   sel_last;
  logic [PLANE_AW-1:0] line_wr_addr, line_rd_addr;

  assign cur.id    = in_tdata[ID_W-1:0];
  assign cur.state = in_tdata[ID_W+STATE_W-1:ID_W];

  assign cx = idx_r[EDGE_BITS-1:0];
  assign cz = idx_r[2*EDGE_BITS-1:EDGE_BITS];
  assign cy = idx_r[3*EDGE_BITS-1:2*EDGE_BITS];
  assign by = cy - coord_t'(1);

  // prefetch the line entry of the next voxel on a transfer
  assign line_wr_addr = idx_r[PLANE_AW-1:0];
  assign line_rd_addr = in_fire ? (line_wr_addr + PLANE_AW'(1)) : line_wr_addr;

  vibc_window u_window (
    .clk      (clk),
    .shift_en (in_fire),
    .wr_addr  (line_wr_addr),
    .rd_addr  (line_rd_addr),
    .vox_in   (cur),
    .nbr      (nbr)
  );

  assign on_edge  = (cx == '0) || (cx == EDGE_MAX) || (by == '0) || (by == EDGE_MAX) ||
                    (cz == '0) || (cz == EDGE_MAX);
  assign enclosed = nbr.xp && nbr.xm && is_solid(cur) && nbr.yb && nbr.zp && nbr.zm;
  assign b_emit   = (cy != '0) && is_solid(nbr.below) && (on_edge || !enclosed);
  assign c_emit   = (cy == EDGE_MAX) && is_solid(cur);

  assign s_any     = s_b_v_r || s_c_v_r;
  assign s_two     = s_b_v_r && s_c_v_r;
  assign out_ld    = s_any && (!out_v_r || out_tready);
  assign in_tready = !s_any || (out_ld && !s_two);
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_x_r <= '0;
      sec_y_r <= '0;
      sec_z_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SECTION_X: sec_x_r <= cfg_wdata;
        CFG_SECTION_Y: sec_y_r <= cfg_wdata[SEC_Y_W-1:0];
        CFG_SECTION_Z: sec_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      s_b_v_r <= 1'b0;
      s_c_v_r <= 1'b0;
    end else if (in_fire) begin
      idx_r   <= idx_r + IDX_BITS'(1);
      s_b_v_r <= b_emit;
      s_c_v_r <= c_emit;
    end else if (out_ld) begin
      if (s_b_v_r) begin
        s_b_v_r <= 1'b0;
      end else begin
        s_c_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_b_r <= nbr.below;
      s_c_r <= cur;
      s_x_r <= cx;
      s_y_r <= cy;
      s_z_r <= cz;
    end
  end

  always_comb begin
    if (s_b_v_r) begin
      sel_vox  = s_b_r;
      sel_y    = s_y_r - coord_t'(1);
      sel_last = !s_c_v_r;
    end else begin
      sel_vox  = s_c_r;
      sel_y    = s_y_r;
      sel_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_ld) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_vox_r  <= sel_vox;
      out_last_r <= sel_last;
      out_wx_r   <= {sec_x_r, s_x_r};
      out_wy_r   <= {sec_y_r, sel_y};
      out_wz_r   <= {sec_z_r, s_z_r};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{OUT_FILL_W{1'b0}}, out_wz_r, out_wy_r, out_wx_r,
                       out_vox_r.state, out_vox_r.id};

  a_out_not_air: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_vox_r.id != '0))
    else $error("visible result carries air");

  a_full_stalls_in: assert property (@(posedge clk) disable iff (!rst_n)
    s_two |-> !in_tready)
    else $error("input taken while decision stage holds two results");

  a_self_top_plane: assert property (@(posedge clk) disable iff (!rst_n)
    s_c_v_r |-> (s_y_r == EDGE_MAX))
    else $error("self result outside top plane");

  a_below_not_bottom: assert property (@(posedge clk) disable iff (!rst_n)
    s_b_v_r |-> (s_y_r != '0))
    else $error("below result from bottom plane item");

endmodule

`default_nettype wire
